### hdl/cct_pkg.sv
`default_nettype none

package cct_pkg;

   // signed bracket depth counter
   localparam int DEPTH_BITS = 16;
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
   localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

   localparam int MODE_BITS = 3;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_SIMPLIFY   = 3'd0,
      MODE_LOWER      = 3'd1,
      MODE_UPPER      = 3'd2,
      MODE_CAP_WORDS  = 3'd3,
      MODE_CAP_FIRST  = 3'd4
   } mode_type;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE   = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE   = 8'h27;
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CASE_OFFSET   = 8'd32;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } item_type;

   function automatic logic [7:0] map_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - CASE_OFFSET;
      end else begin
         case (c)
            8'd129: r = 8'd154;
            8'd164: r = 8'd165;
            8'd132: r = 8'd142;
            8'd134: r = 8'd143;
            8'd130: r = 8'd144;
            8'd148: r = 8'd153;
            8'd135: r = 8'd128;
            8'd145: r = 8'd146;
            default: r = c;
         endcase
      end
      return r;
   endfunction

   function automatic logic [7:0] map_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + CASE_OFFSET;
      end else begin
         case (c)
            8'd154: r = 8'd129;
            8'd165: r = 8'd164;
            8'd142: r = 8'd132;
            8'd143: r = 8'd134;
            8'd144: r = 8'd130;
            8'd153: r = 8'd148;
            8'd128: r = 8'd135;
            8'd146: r = 8'd145;
            default: r = c;
         endcase
      end
      return r;
   endfunction

   function automatic logic [7:0] map_simple(input logic [7:0] c);
      logic [7:0] f;
      logic [7:0] r;
      f = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         f = c + CASE_OFFSET;
      end
      case (f)
         8'd129, 8'd150, 8'd151, 8'd154, 8'd163: r = 8'h75;
         8'd152: r = 8'h79;
         8'd164, 8'd165: r = 8'h6E;
         8'd131, 8'd132, 8'd133, 8'd134, 8'd142,
         8'd143, 8'd145, 8'd146, 8'd160: r = 8'h61;
         8'd130, 8'd136, 8'd137, 8'd138, 8'd144: r = 8'h65;
         8'd139, 8'd140, 8'd141, 8'd161: r = 8'h69;
         8'd147, 8'd148, 8'd149, 8'd153, 8'd162: r = 8'h6F;
         8'd128, 8'd135: r = 8'h63;
         default: r = f;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/cct_core.sv
`default_nettype none

module cct_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire cct_pkg::item_type    item,
   input  wire logic [cct_pkg::MODE_BITS-1:0] mode,
   output logic [7:0]                result
);

   logic [cct_pkg::DEPTH_BITS-1:0] depth_ff, depth_in, depth_stepped;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] prev_prev_ff, prev_prev_in;
   logic [1:0] pos_ff, pos_in;
   logic       at_start_ff, at_start_in;
   logic       first_done_ff, first_done_in;

   logic [7:0] c;
   logic [7:0] upper_c;
   logic       is_open, is_close, depth_pos, bracket_hit, trig, c_blank;

   always_comb begin
      c       = item.code;
      upper_c = cct_pkg::map_upper(c);
      is_open  = (c == cct_pkg::CHAR_LBRACKET);
      is_close = (c == cct_pkg::CHAR_RBRACKET);
      depth_pos = !depth_ff[cct_pkg::DEPTH_BITS-1] && (depth_ff != '0);
      bracket_hit = is_open || is_close || depth_pos;
      c_blank = (c == cct_pkg::CHAR_SPACE) || (c == cct_pkg::CHAR_DQUOTE);

      // saturating depth step
      depth_stepped = depth_ff;
      if (is_open && depth_ff != cct_pkg::DEPTH_MAX) begin
         depth_stepped = depth_ff + cct_pkg::DEPTH_ONE;
      end else if (is_close && depth_ff != cct_pkg::DEPTH_MIN) begin
         depth_stepped = depth_ff - cct_pkg::DEPTH_ONE;
      end

      trig = at_start_ff
          || (prev_ff == cct_pkg::CHAR_SPACE) || (prev_ff == cct_pkg::CHAR_DQUOTE)
          || ((prev_ff == cct_pkg::CHAR_SQUOTE) && (pos_ff == 2'd2)
              && ((prev_prev_ff == cct_pkg::CHAR_SPACE)
                  || (prev_prev_ff == cct_pkg::CHAR_COMMA)));

      result        = c;
      depth_in      = depth_ff;
      at_start_in   = at_start_ff;
      first_done_in = first_done_ff;

      unique case (mode)
         cct_pkg::MODE_SIMPLIFY: result = cct_pkg::map_simple(c);
         cct_pkg::MODE_LOWER:    result = cct_pkg::map_lower(c);
         cct_pkg::MODE_UPPER:    result = upper_c;
         cct_pkg::MODE_CAP_WORDS: begin
            depth_in = depth_stepped;
            if (!bracket_hit && trig) begin
               result      = upper_c;
               at_start_in = 1'b0;
            end
         end
         cct_pkg::MODE_CAP_FIRST: begin
            // once the first word is done, brackets are no longer tracked
            if (!first_done_ff) begin
               depth_in = depth_stepped;
               if (!bracket_hit && trig) begin
                  if (upper_c != c) begin
                     result        = upper_c;
                     first_done_in = 1'b1;
                  end else if (!c_blank) begin
                     first_done_in = 1'b1;
                  end else begin
                     at_start_in = 1'b0;
                  end
               end
            end
         end
         default: result = c;
      endcase

      prev_in      = c;
      prev_prev_in = prev_ff;
      pos_in       = (pos_ff == 2'd2) ? pos_ff : pos_ff + 2'd1;

      // end of string clears all context
      if (item.last) begin
         depth_in      = '0;
         prev_in       = '0;
         prev_prev_in  = '0;
         pos_in        = '0;
         at_start_in   = 1'b1;
         first_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         prev_ff       <= '0;
         prev_prev_ff  <= '0;
         pos_ff        <= '0;
         at_start_ff   <= 1'b1;
         first_done_ff <= 1'b0;
      end else if (step) begin
         depth_ff      <= depth_in;
         prev_ff       <= prev_in;
         prev_prev_ff  <= prev_prev_in;
         pos_ff        <= pos_in;
         at_start_ff   <= at_start_in;
         first_done_ff <= first_done_in;
      end
   end

endmodule

`default_nettype wire

### hdl/cp437_case_transform.sv
// channel | direction | ports                                  | meaning
// req     | in        | req_valid/req_ready, char_in, last_in  | one code page 437 byte
// rsp     | out       | rsp_valid/rsp_ready, char_out, last_out| transformed byte
// csr     | in        | csr_valid/csr_ready, csr_mode          | transform select, always ready
//
// one byte per cycle sustained while rsp_ready holds; req reaches rsp through
// the input register, then the result register behind the per-byte lookup
// the context of a string is updated as a byte moves into the result register
// a stalled rsp holds both stages, req_ready drops only when both are full
// reset clears mode, context and both valid flags
`default_nettype none

module cp437_case_transform (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_last_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_last_out,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [cct_pkg::MODE_BITS-1:0] csr_mode
);

   logic [cct_pkg::MODE_BITS-1:0] mode_ff;
   logic              in_valid_ff;
   cct_pkg::item_type in_item_ff;
   logic              out_valid_ff;
   logic [7:0]        out_char_ff;
   logic              out_last_ff;
   logic              advance;
   logic [7:0]        result;

   assign csr_ready = 1'b1;

   // a transaction moves from the input register to the result register
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cct_pkg::MODE_SIMPLIFY;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_mode;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.code <= req_char_in;
         in_item_ff.last <= req_last_in;
      end
      if (advance) begin
         out_char_ff <= result;
         out_last_ff <= in_item_ff.last;
      end
   end

   cct_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .mode   (mode_ff),
      .result (result)
   );

   assign rsp_valid    = out_valid_ff;
   assign rsp_char_out = out_char_ff;
   assign rsp_last_out = out_last_ff;

`ifndef ASSERT_OFF
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("input register changed while stalled");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid && (rsp_last_out == $past(in_item_ff.last)))
      else $error("result last flag does not follow its transaction");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("input stalled while pipeline can move");
`endif

endmodule

`default_nettype wire

### dv/cp437_case_checker.sv
module cp437_case_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [7:0]                    req_char_in,
   input  wire logic                          req_last_in,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [7:0]                    rsp_char_out,
   input  wire logic                          rsp_last_out,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [cct_pkg::MODE_BITS-1:0] csr_mode,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import cct_pkg::*;

   logic [MODE_BITS-1:0]         cur_mode;
   logic signed [DEPTH_BITS-1:0] depth;
   logic [7:0]                   prev_c;
   logic [7:0]                   prev2_c;
   logic [1:0]                   seen;
   logic                         at_start;
   logic                         first_done;
   item_type                     expected_bytes[$];

   function automatic logic [7:0] upper_437(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A) return c - 8'd32;
      case (c)
         8'd129: return 8'd154;
         8'd164: return 8'd165;
         8'd132: return 8'd142;
         8'd134: return 8'd143;
         8'd130: return 8'd144;
         8'd148: return 8'd153;
         8'd135: return 8'd128;
         8'd145: return 8'd146;
         default: return c;
      endcase
   endfunction

   function automatic logic [7:0] lower_437(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
      case (c)
         8'd154: return 8'd129;
         8'd165: return 8'd164;
         8'd142: return 8'd132;
         8'd143: return 8'd134;
         8'd144: return 8'd130;
         8'd153: return 8'd148;
         8'd128: return 8'd135;
         8'd146: return 8'd145;
         default: return c;
      endcase
   endfunction

   // fold case first, then strip accents to the plain letter
   function automatic logic [7:0] plain_437(input logic [7:0] c);
      logic [7:0] f;
      f = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
      case (f)
         8'd129, 8'd150, 8'd151, 8'd154, 8'd163: return "u";
         8'd152: return "y";
         8'd164, 8'd165: return "n";
         8'd131, 8'd132, 8'd133, 8'd134, 8'd142, 8'd143, 8'd145, 8'd146, 8'd160:
            return "a";
         8'd130, 8'd136, 8'd137, 8'd138, 8'd144: return "e";
         8'd139, 8'd140, 8'd141, 8'd161: return "i";
         8'd147, 8'd148, 8'd149, 8'd153, 8'd162: return "o";
         8'd128, 8'd135: return "c";
         default: return f;
      endcase
   endfunction

   function automatic logic word_trigger();
      if (at_start) return 1'b1;
      if (prev_c == CHAR_SPACE || prev_c == CHAR_DQUOTE) return 1'b1;
      return prev_c == CHAR_SQUOTE && seen >= 2'd2 &&
             (prev2_c == CHAR_SPACE || prev2_c == CHAR_COMMA);
   endfunction

   // updates the saturating depth, true for brackets and bracketed bytes
   function automatic logic in_brackets(input logic [7:0] c);
      if (c == CHAR_LBRACKET) begin
         if (depth != $signed(DEPTH_MAX)) depth = depth + $signed(DEPTH_ONE);
         return 1'b1;
      end
      if (c == CHAR_RBRACKET) begin
         if (depth != $signed(DEPTH_MIN)) depth = depth - $signed(DEPTH_ONE);
         return 1'b1;
      end
      return depth > 0;
   endfunction

   function automatic void clear_context();
      depth      = '0;
      prev_c     = '0;
      prev2_c    = '0;
      seen       = '0;
      at_start   = 1'b1;
      first_done = 1'b0;
   endfunction

   task automatic transform_byte(input logic [7:0] c, input logic l, output logic [7:0] r);
      logic [7:0] u;
      r = c;
      u = upper_437(c);
      case (cur_mode)
         MODE_SIMPLIFY: r = plain_437(c);
         MODE_LOWER:    r = lower_437(c);
         MODE_UPPER:    r = u;
         MODE_CAP_WORDS: begin
            if (!in_brackets(c) && word_trigger()) begin
               r = u;
               at_start = 1'b0;
            end
         end
         MODE_CAP_FIRST: begin
            // once the first word is done the depth is no longer tracked
            if (!first_done) begin
               if (!in_brackets(c) && word_trigger()) begin
                  if (u != c) begin
                     r = u;
                     first_done = 1'b1;
                  end else if (c != CHAR_SPACE && c != CHAR_DQUOTE) begin
                     first_done = 1'b1;
                  end else begin
                     at_start = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
      prev2_c = prev_c;
      prev_c  = c;
      if (seen < 2'd2) seen = seen + 2'd1;
      if (l) clear_context();
   endtask

   always @(posedge clock) begin
      item_type   exp_item;
      logic [7:0] r;
      if (reset) begin
         expected_bytes.delete();
         cur_mode   = MODE_SIMPLIFY;
         fail_count = 0;
         checked    = 0;
         clear_context();
      end else begin
         if (csr_valid && csr_ready) cur_mode = csr_mode;
         if (req_valid && req_ready) begin
            transform_byte(req_char_in, req_last_in, r);
            expected_bytes.push_back('{code: r, last: req_last_in});
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transaction, expected none, actual char_out %h last_out %b",
                        $time, rsp_char_out, rsp_last_out);
            end else begin
               exp_item = expected_bytes.pop_front();
               checked++;
               if (rsp_char_out !== exp_item.code) begin
                  fail_count++;
                  $display("%0t: char_out mismatch, expected %h, actual %h",
                           $time, exp_item.code, rsp_char_out);
               end
               if (rsp_last_out !== exp_item.last) begin
                  fail_count++;
                  $display("%0t: last_out mismatch, expected %b, actual %b",
                           $time, exp_item.last, rsp_last_out);
               end
            end
         end
      end
      pending = expected_bytes.size();
   end

endmodule

### dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cct_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int STALL_CYCLES = 300;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_char_in;
   logic                 req_last_in;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [7:0]           rsp_char_out;
   logic                 rsp_last_out;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [MODE_BITS-1:0] csr_mode;

   int         fail_count;
   int         pending;
   int         checked;
   int         cycles;
   int         bytes_sent;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         stall_left;
   logic       stall_req;
   logic [7:0] modes_seen;

   cp437_case_transform u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_in  (req_char_in),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out),
      .rsp_last_out (rsp_last_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_mode     (csr_mode)
   );

   cp437_case_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_in  (req_char_in),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out),
      .rsp_last_out (rsp_last_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_mode     (csr_mode),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d transactions still expected", cycles, pending);
      $display("status: fail");
      $finish;
   end

   // receiver: random backpressure, plus one long hold-off on request
   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_req) begin
            stall_left = STALL_CYCLES;
            stall_req  = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] c, input logic l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      req_last_in <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic close);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 11))
         0, 1, 2, 3: return 8'($urandom_range(8'h61, 8'h7A));
         4:          return 8'($urandom_range(8'h41, 8'h5A));
         5, 6:       return CHAR_SPACE;
         7, 8: begin
            case ($urandom_range(0, 4))
               0:       return CHAR_DQUOTE;
               1:       return CHAR_SQUOTE;
               2:       return CHAR_COMMA;
               3:       return CHAR_LBRACKET;
               default: return CHAR_RBRACKET;
            endcase
         end
         9:          return 8'($urandom_range(128, 165));
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // words with punctuation; a few strings stay open across a mode change
   task automatic send_string();
      int   len;
      logic close;
      len   = $urandom_range(1, 24);
      close = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < len; i++) send_byte(pick_byte(), close && i == len - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic set_mode(input logic [MODE_BITS-1:0] m);
      settle();
      csr_valid <= 1'b1;
      csr_mode  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      modes_seen[m] = 1'b1;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_start;
      int block_end;
      int draw;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_in   = '0;
      req_last_in   = 1'b0;
      csr_valid     = 1'b0;
      csr_mode      = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_req     = 1'b0;
      bytes_sent    = 0;
      modes_seen    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, every mode, quoting and bracket corner cases
      set_mode(MODE_SIMPLIFY);
      send_byte(8'h00, 1'b0);
      send_byte("Z", 1'b0);
      send_byte(8'd128, 1'b0);
      send_byte(8'd165, 1'b0);
      send_byte(8'hFF, 1'b1);
      set_mode(MODE_LOWER);
      send_byte("A", 1'b0);
      send_byte(8'd146, 1'b0);
      send_byte(8'd154, 1'b1);
      set_mode(MODE_UPPER);
      send_byte("z", 1'b0);
      send_byte(8'd135, 1'b1);
      // stray closing bracket, quote after comma, bracketed word, double quote
      set_mode(MODE_CAP_WORDS);
      send_text("]a ,'b[x]\"q", 1'b1);
      set_mode(MODE_CAP_FIRST);
      send_text(" \"xy", 1'b1);
      set_mode(3'd7);
      send_byte("m", 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 77;
            end
            1: begin
               send_idle_pct = 77;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 500) begin
            draw = $urandom_range(0, 11);
            set_mode(draw > 7 ? (draw[0] ? MODE_CAP_FIRST : MODE_CAP_WORDS) : draw[2:0]);
            block_end = bytes_sent + $urandom_range(20, 80);
            while (bytes_sent < block_end) send_string();
         end
      end

      // output held off while the sender keeps offering, so the input stalls
      set_mode(MODE_CAP_WORDS);
      stall_req = 1'b1;
      repeat (6) send_string();

      settle();
      repeat (4) @(negedge clock);
      $display("summary: %0d transactions checked, mode values written %b", checked, modes_seen);
      $display("summary: three idle mixes and a %0d cycle output stall with the input held full",
               STALL_CYCLES);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule

### files.f
hdl/cct_pkg.sv
hdl/cct_core.sv
hdl/cp437_case_transform.sv
dv/cp437_case_checker.sv
dv/tb.sv
